// ===== hw/rtl/ecomp_pkg.sv =====
// Shared types and constants of the environmental sensor compensation block.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package ecomp_pkg;

    // Configuration register indexes and widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_B   = 3'd5;

    // Pipeline geometry
    localparam int FRONT_STAGES = 14;
    localparam int DIV_STEP     = 2;
    localparam int DIV_W        = 64;
    localparam int DEN_W        = 31;
    localparam int DIV_STAGES   = DIV_W / DIV_STEP;

    // Compensation constants
    localparam logic signed [32:0] P_TEMP_OFS = 33'sd128000;
    localparam logic signed [31:0] H_TEMP_OFS = 32'sd76800;
    localparam logic [20:0]        P_BASE     = 21'd1048576;
    localparam logic [63:0]        P_SCALE    = 64'd3125;
    localparam logic [63:0]        P_PA_OFS   = 64'h0000_8000_0000_0000;
    localparam logic signed [31:0] H_MAX      = 32'sd419430400;
    localparam logic signed [31:0] H_X_RND    = 32'sd16384;
    localparam logic signed [31:0] H_Y_OFS    = 32'sd2097152;
    localparam logic signed [31:0] H_Y3_OFS   = 32'sd32768;
    localparam logic signed [31:0] H_Y_RND    = 32'sd8192;
    localparam logic [17:0]        H_PCT_RND  = 18'd512;

    typedef struct packed {
        logic [19:0] adc_pressure;
        logic [19:0] adc_temperature;
        logic [15:0] adc_humidity;
    } sample_t;

    typedef struct packed {
        logic [31:0] temperature_centi;
        logic [31:0] pressure_q24_8;
        logic        pressure_valid;
        logic [16:0] humidity_q22_10;
        logic [6:0]  humidity_percent;
    } result_t;

    // Calibration coefficients unpacked from the configuration registers
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [11:0] h4;
        logic [11:0] h5;
        logic [7:0]  h6;
    } coeffs_t;

    // Finished temperature and humidity values riding along with the divider
    typedef struct packed {
        logic [31:0] tcent;
        logic [16:0] hq;
        logic [6:0]  hp;
    } side_t;

    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
        side_t            side;
    } div_in_t;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic             pvalid;
        logic [DIV_W-1:0] quot;
        side_t            side;
    } div_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/env_sensor_compensation.sv =====
// Environmental sensor compensation, top level.
// Throughput is one transaction per cycle, busy stays low. The 64-bit divider,
// 32 stages of two quotient bits each, sets most of the latency.
// Reset clears all valid bits and the calibration registers to zero. The
// receiver must take every result in its strobe cycle, or a result is lost;
// the block itself does not enforce this.
`default_nettype none

module env_sensor_compensation
    import ecomp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sample_t               sample,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [47:0] temp_coeffs_reg;
    logic [47:0] press_coeffs_a_reg;
    logic [47:0] press_coeffs_b_reg;
    logic [47:0] press_coeffs_c_reg;
    logic [31:0] hum_coeffs_a_reg;
    logic [31:0] hum_coeffs_b_reg;
    coeffs_t     coef;
    div_in_t     front_out;
    div_out_t    div_out;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg    <= '0;
            press_coeffs_a_reg <= '0;
            press_coeffs_b_reg <= '0;
            press_coeffs_c_reg <= '0;
            hum_coeffs_a_reg   <= '0;
            hum_coeffs_b_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMP:    temp_coeffs_reg    <= cfg_data;
                CFG_PRESS_A: press_coeffs_a_reg <= cfg_data;
                CFG_PRESS_B: press_coeffs_b_reg <= cfg_data;
                CFG_PRESS_C: press_coeffs_c_reg <= cfg_data;
                CFG_HUM_A:   hum_coeffs_a_reg   <= cfg_data[31:0];
                CFG_HUM_B:   hum_coeffs_b_reg   <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    // unpack the calibration coefficients
    assign coef.t1 = temp_coeffs_reg[15:0];
    assign coef.t2 = temp_coeffs_reg[31:16];
    assign coef.t3 = temp_coeffs_reg[47:32];
    assign coef.p1 = press_coeffs_a_reg[15:0];
    assign coef.p2 = press_coeffs_a_reg[31:16];
    assign coef.p3 = press_coeffs_a_reg[47:32];
    assign coef.p4 = press_coeffs_b_reg[15:0];
    assign coef.p5 = press_coeffs_b_reg[31:16];
    assign coef.p6 = press_coeffs_b_reg[47:32];
    assign coef.p7 = press_coeffs_c_reg[15:0];
    assign coef.p8 = press_coeffs_c_reg[31:16];
    assign coef.p9 = press_coeffs_c_reg[47:32];
    assign coef.h1 = hum_coeffs_a_reg[7:0];
    assign coef.h2 = hum_coeffs_a_reg[23:8];
    assign coef.h3 = hum_coeffs_a_reg[31:24];
    assign coef.h4 = hum_coeffs_b_reg[11:0];
    assign coef.h5 = hum_coeffs_b_reg[23:12];
    assign coef.h6 = hum_coeffs_b_reg[31:24];

    // every cycle takes a transaction
    assign busy = 1'b0;

    ecomp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .in_sample (sample),
        .coef      (coef),
        .dout      (front_out)
    );

    ecomp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (front_out),
        .dout  (div_out)
    );

    ecomp_post u_post (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (div_out),
        .coef   (coef),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ecomp_front.sv =====
// Front pipeline: temperature, humidity and the pressure dividend and divisor.
// Depends on ecomp_pkg.
`default_nettype none

module ecomp_front
    import ecomp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  sample_t in_sample,
    input  coeffs_t coef,
    output div_in_t dout
);

    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_next;

    // stage 0: raw readings
    sample_t s0_smp_reg;
    logic signed [17:0] t_dx;
    logic signed [16:0] t_dd;
    logic signed [31:0] s1_v1p_next, s1_v1p_reg;
    logic signed [31:0] s1_dd_next, s1_dd_reg;
    sample_t s1_smp_reg;

    logic signed [31:0] ddq;
    logic signed [31:0] s2_v1_next, s2_v1_reg;
    logic signed [31:0] s2_m_next, s2_m_reg;
    sample_t s2_smp_reg;

    logic signed [31:0] s3_tf_next, s3_tf_reg;
    sample_t s3_smp_reg;

    logic signed [31:0] t5;
    logic signed [31:0] s4_tcent_next, s4_tcent_reg;
    logic signed [32:0] s4_a_next, s4_a_reg;
    logic signed [31:0] s4_h_next, s4_h_reg;
    sample_t s4_smp_reg;

    logic signed [63:0] s5_aa_next, s5_aa_reg;
    logic signed [48:0] s5_ap5_next, s5_ap5_reg;
    logic signed [48:0] s5_ap2_next, s5_ap2_reg;
    logic signed [31:0] s5_hh5_next, s5_hh5_reg;
    logic signed [31:0] s5_hh6_next, s5_hh6_reg;
    logic signed [31:0] s5_hh3_next, s5_hh3_reg;
    logic signed [31:0] s5_tcent_reg;
    sample_t s5_smp_reg;

    logic signed [31:0] ah_x, h4_x, x_sum;
    logic signed [63:0] s6_baa_next, s6_baa_reg;
    logic signed [63:0] s6_caa_next, s6_caa_reg;
    logic signed [31:0] s6_x_next, s6_x_reg;
    logic signed [31:0] s6_y1_next, s6_y1_reg;
    logic signed [31:0] s6_y2_next, s6_y2_reg;
    logic signed [48:0] s6_ap5_reg, s6_ap2_reg;
    logic signed [31:0] s6_tcent_reg;
    logic [19:0]        s6_ap_reg;

    logic signed [63:0] s7_b_next, s7_b_reg;
    logic signed [63:0] s7_a2_next, s7_a2_reg;
    logic signed [31:0] s7_y_next, s7_y_reg;
    logic signed [31:0] s7_x_reg, s7_tcent_reg;
    logic [19:0]        s7_ap_reg;

    logic [20:0]        pdiff;
    logic [63:0]        s8_pa_next, s8_pa_reg;
    logic [63:0]        s8_nm_next, s8_nm_reg;
    logic signed [31:0] s8_y3_next, s8_y3_reg;
    logic signed [31:0] s8_x_reg, s8_tcent_reg;

    logic [DEN_W-1:0]   s9_den_next, s9_den_reg;
    logic [63:0]        s9_num_next, s9_num_reg;
    logic signed [31:0] s9_y4_next, s9_y4_reg;
    logic signed [31:0] s9_x_reg, s9_tcent_reg;

    logic signed [31:0] y_sum, y5;
    logic signed [31:0] s10_hx_next, s10_hx_reg;
    logic [63:0]        s10_num_reg;
    logic [DEN_W-1:0]   s10_den_reg;
    logic signed [31:0] s10_tcent_reg;

    logic signed [31:0] hs;
    logic signed [31:0] s11_ss_next, s11_ss_reg;
    logic signed [31:0] s11_hx_reg, s11_tcent_reg;
    logic [63:0]        s11_num_reg;
    logic [DEN_W-1:0]   s11_den_reg;

    logic signed [31:0] s12_t_next, s12_t_reg;
    logic signed [31:0] s12_hx_reg, s12_tcent_reg;
    logic [63:0]        s12_num_reg;
    logic [DEN_W-1:0]   s12_den_reg;

    logic signed [31:0] hd;
    logic [28:0]        hc;
    logic [16:0]        s13_hq_next, s13_hq_reg;
    logic signed [31:0] s13_tcent_reg;
    logic [63:0]        s13_num_reg;
    logic [DEN_W-1:0]   s13_den_reg;
    logic [17:0]        hp_sum;

    // advance the valid bits
    assign vld_next = {vld_reg[FRONT_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // temperature: first products
    assign t_dx = $signed({1'b0, s0_smp_reg.adc_temperature[19:3]})
                - $signed({1'b0, coef.t1, 1'b0});
    assign t_dd = $signed({1'b0, s0_smp_reg.adc_temperature[19:4]})
                - $signed({1'b0, coef.t1});
    assign s1_v1p_next = 32'(t_dx) * 32'($signed(coef.t2));
    assign s1_dd_next  = 32'(t_dd) * 32'(t_dd);

    // temperature: scale and second product
    assign s2_v1_next = s1_v1p_reg >>> 11;
    assign ddq        = s1_dd_reg >>> 12;
    assign s2_m_next  = ddq * 32'($signed(coef.t3));

    // fine temperature
    assign s3_tf_next = s2_v1_reg + (s2_m_reg >>> 14);

    // centidegrees and offsets for the pressure and humidity paths
    assign t5            = s3_tf_reg * 32'sd5 + 32'sd128;
    assign s4_tcent_next = t5 >>> 8;
    assign s4_a_next     = 33'(s3_tf_reg) - P_TEMP_OFS;
    assign s4_h_next     = s3_tf_reg - H_TEMP_OFS;

    // products of the temperature offsets
    assign s5_aa_next  = 64'(s4_a_reg) * 64'(s4_a_reg);
    assign s5_ap5_next = 49'(s4_a_reg) * 49'($signed(coef.p5));
    assign s5_ap2_next = 49'(s4_a_reg) * 49'($signed(coef.p2));
    assign s5_hh5_next = s4_h_reg * 32'($signed(coef.h5));
    assign s5_hh6_next = s4_h_reg * 32'($signed(coef.h6));
    assign s5_hh3_next = s4_h_reg * $signed(32'(coef.h3));

    // squared offset times coefficients; humidity base terms
    assign s6_baa_next = s5_aa_reg * 64'($signed(coef.p6));
    assign s6_caa_next = s5_aa_reg * 64'($signed(coef.p3));
    assign ah_x        = $signed({2'b00, s5_smp_reg.adc_humidity, 14'd0});
    assign h4_x        = 32'($signed(coef.h4)) <<< 20;
    assign x_sum       = ah_x - h4_x - s5_hh5_reg + H_X_RND;
    assign s6_x_next   = x_sum >>> 15;
    assign s6_y1_next  = s5_hh6_reg >>> 10;
    assign s6_y2_next  = (s5_hh3_reg >>> 11) + H_Y3_OFS;

    // sum the pressure terms
    assign s7_b_next  = s6_baa_reg + (64'(s6_ap5_reg) <<< 17)
                      + (64'($signed(coef.p4)) <<< 35);
    assign s7_a2_next = (s6_caa_reg >>> 8) + (64'(s6_ap2_reg) <<< 12);
    assign s7_y_next  = s6_y1_reg * s6_y2_reg;

    // divisor product and raw dividend
    assign s8_pa_next = (s7_a2_reg + P_PA_OFS) * 64'(coef.p1);
    assign pdiff      = P_BASE - 21'(s7_ap_reg);
    assign s8_nm_next = {12'd0, pdiff, 31'd0} - s7_b_reg;
    assign s8_y3_next = (s7_y_reg >>> 10) + H_Y_OFS;

    // final dividend and divisor
    assign s9_den_next = s8_pa_reg[63:33];
    assign s9_num_next = s8_nm_reg * P_SCALE;
    assign s9_y4_next  = s8_y3_reg * 32'($signed(coef.h2));

    // humidity product
    assign y_sum       = s9_y4_reg + H_Y_RND;
    assign y5          = y_sum >>> 14;
    assign s10_hx_next = s9_x_reg * y5;

    // humidity correction square
    assign hs          = s10_hx_reg >>> 15;
    assign s11_ss_next = hs * hs;

    // humidity correction scaled by H1
    assign s12_t_next = (s11_ss_reg >>> 7) * $signed(32'(coef.h1));

    // clamp and scale humidity
    assign hd = s12_hx_reg - (s12_t_reg >>> 4);
    always_comb
    begin
        if (hd[31])
        begin
            hc = '0;
        end
        else if (hd > H_MAX)
        begin
            hc = H_MAX[28:0];
        end
        else
        begin
            hc = hd[28:0];
        end
    end
    assign s13_hq_next = hc[28:12];

    // round to whole percent and hand off to the divider
    assign hp_sum          = {1'b0, s13_hq_reg} + H_PCT_RND;
    assign dout.valid      = vld_reg[FRONT_STAGES-1];
    assign dout.num        = s13_num_reg;
    assign dout.den        = s13_den_reg;
    assign dout.side.tcent = s13_tcent_reg;
    assign dout.side.hq    = s13_hq_reg;
    assign dout.side.hp    = hp_sum[16:10];

    // pipeline registers
    always_ff @(posedge clk)
    begin
        s0_smp_reg    <= in_sample;
        s1_v1p_reg    <= s1_v1p_next;
        s1_dd_reg     <= s1_dd_next;
        s1_smp_reg    <= s0_smp_reg;
        s2_v1_reg     <= s2_v1_next;
        s2_m_reg      <= s2_m_next;
        s2_smp_reg    <= s1_smp_reg;
        s3_tf_reg     <= s3_tf_next;
        s3_smp_reg    <= s2_smp_reg;
        s4_tcent_reg  <= s4_tcent_next;
        s4_a_reg      <= s4_a_next;
        s4_h_reg      <= s4_h_next;
        s4_smp_reg    <= s3_smp_reg;
        s5_aa_reg     <= s5_aa_next;
        s5_ap5_reg    <= s5_ap5_next;
        s5_ap2_reg    <= s5_ap2_next;
        s5_hh5_reg    <= s5_hh5_next;
        s5_hh6_reg    <= s5_hh6_next;
        s5_hh3_reg    <= s5_hh3_next;
        s5_tcent_reg  <= s4_tcent_reg;
        s5_smp_reg    <= s4_smp_reg;
        s6_baa_reg    <= s6_baa_next;
        s6_caa_reg    <= s6_caa_next;
        s6_x_reg      <= s6_x_next;
        s6_y1_reg     <= s6_y1_next;
        s6_y2_reg     <= s6_y2_next;
        s6_ap5_reg    <= s5_ap5_reg;
        s6_ap2_reg    <= s5_ap2_reg;
        s6_tcent_reg  <= s5_tcent_reg;
        s6_ap_reg     <= s5_smp_reg.adc_pressure;
        s7_b_reg      <= s7_b_next;
        s7_a2_reg     <= s7_a2_next;
        s7_y_reg      <= s7_y_next;
        s7_x_reg      <= s6_x_reg;
        s7_tcent_reg  <= s6_tcent_reg;
        s7_ap_reg     <= s6_ap_reg;
        s8_pa_reg     <= s8_pa_next;
        s8_nm_reg     <= s8_nm_next;
        s8_y3_reg     <= s8_y3_next;
        s8_x_reg      <= s7_x_reg;
        s8_tcent_reg  <= s7_tcent_reg;
        s9_den_reg    <= s9_den_next;
        s9_num_reg    <= s9_num_next;
        s9_y4_reg     <= s9_y4_next;
        s9_x_reg      <= s8_x_reg;
        s9_tcent_reg  <= s8_tcent_reg;
        s10_hx_reg    <= s10_hx_next;
        s10_num_reg   <= s9_num_reg;
        s10_den_reg   <= s9_den_reg;
        s10_tcent_reg <= s9_tcent_reg;
        s11_ss_reg    <= s11_ss_next;
        s11_hx_reg    <= s10_hx_reg;
        s11_num_reg   <= s10_num_reg;
        s11_den_reg   <= s10_den_reg;
        s11_tcent_reg <= s10_tcent_reg;
        s12_t_reg     <= s12_t_next;
        s12_hx_reg    <= s11_hx_reg;
        s12_num_reg   <= s11_num_reg;
        s12_den_reg   <= s11_den_reg;
        s12_tcent_reg <= s11_tcent_reg;
        s13_hq_reg    <= s13_hq_next;
        s13_num_reg   <= s12_num_reg;
        s13_den_reg   <= s12_den_reg;
        s13_tcent_reg <= s12_tcent_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ecomp_div.sv =====
// Pipelined signed divider for the pressure path, two quotient bits per stage.
// Depends on ecomp_pkg.
`default_nettype none

module ecomp_div
    import ecomp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_in_t  din,
    output div_out_t dout
);

    logic [DIV_STAGES:0] vld_reg;
    logic [DIV_STAGES:0] vld_next;
    logic             neg_reg [DIV_STAGES+1];
    logic             pv_reg  [DIV_STAGES+1];
    side_t            side_reg[DIV_STAGES+1];
    logic [DIV_W-1:0] dq_reg  [DIV_STAGES+1];
    logic [DEN_W-1:0] rem_reg [DIV_STAGES+1];
    logic [DEN_W-1:0] mb_reg  [DIV_STAGES+1];
    logic [DIV_W-1:0] dq_next [DIV_STAGES];
    logic [DEN_W-1:0] rem_next[DIV_STAGES];

    logic             na, nb;
    logic [DIV_W-1:0] mag_a;
    logic [DEN_W-1:0] mag_b;

    // take magnitudes of the operands at entry
    assign na    = din.num[DIV_W-1];
    assign nb    = din.den[DEN_W-1];
    assign mag_a = na ? ('0 - din.num) : din.num;
    assign mag_b = nb ? ('0 - din.den) : din.den;

    // restoring steps of every stage
    always_comb
    begin
        logic [DEN_W:0]   r;
        logic [DIV_W-1:0] q;
        logic [DEN_W-1:0] rm;
        for (int g = 0; g < DIV_STAGES; g++)
        begin
            q  = dq_reg[g];
            rm = rem_reg[g];
            for (int k = 0; k < DIV_STEP; k++)
            begin
                r = {rm, q[DIV_W-1]};
                q = {q[DIV_W-2:0], 1'b0};
                if (r >= {1'b0, mb_reg[g]})
                begin
                    r    = r - {1'b0, mb_reg[g]};
                    q[0] = 1'b1;
                end
                rm = r[DEN_W-1:0];
            end
            dq_next[g]  = q;
            rem_next[g] = rm;
        end
    end

    // advance the valid bits
    assign vld_next = {vld_reg[DIV_STAGES-1:0], din.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        neg_reg[0]  <= na ^ nb;
        pv_reg[0]   <= (din.den != '0);
        side_reg[0] <= din.side;
        dq_reg[0]   <= mag_a;
        rem_reg[0]  <= '0;
        mb_reg[0]   <= mag_b;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            neg_reg[i+1]  <= neg_reg[i];
            pv_reg[i+1]   <= pv_reg[i];
            side_reg[i+1] <= side_reg[i];
            dq_reg[i+1]   <= dq_next[i];
            rem_reg[i+1]  <= rem_next[i];
            mb_reg[i+1]   <= mb_reg[i];
        end
    end

    assign dout.valid  = vld_reg[DIV_STAGES];
    assign dout.neg    = neg_reg[DIV_STAGES];
    assign dout.pvalid = pv_reg[DIV_STAGES];
    assign dout.quot   = dq_reg[DIV_STAGES];
    assign dout.side   = side_reg[DIV_STAGES];

endmodule

`default_nettype wire

// ===== hw/rtl/ecomp_post.sv =====
// Back pipeline: quotient correction terms, pressure saturation and result register.
// Depends on ecomp_pkg.
`default_nettype none

module ecomp_post
    import ecomp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_out_t din,
    input  coeffs_t  coef,
    output logic     done,
    output result_t  result
);

    logic [4:0] vld_reg;
    logic [4:0] vld_next;
    logic       done_reg;
    logic       pv_reg  [5];
    side_t      side_reg[5];

    logic signed [63:0] p0_p_next, p0_p_reg;
    logic signed [63:0] q13;
    logic [31:0]        ql, qh;
    logic [63:0]        p1_ll_next, p1_ll_reg;
    logic [31:0]        p1_lh_next, p1_lh_reg;
    logic signed [63:0] p1_eraw_next, p1_eraw_reg;
    logic signed [63:0] p1_p_reg;
    logic signed [63:0] p2_qq_next, p2_qq_reg;
    logic signed [63:0] p2_e_next, p2_e_reg;
    logic signed [63:0] p2_p_reg;
    logic signed [63:0] p3_craw_next, p3_craw_reg;
    logic signed [63:0] p3_e_reg, p3_p_reg;
    logic signed [63:0] p4_s_next, p4_s_reg;
    logic signed [63:0] pr;
    logic [31:0]        press;
    result_t            result_next, result_reg;

    // restore the quotient sign
    assign p0_p_next = din.neg ? ('0 - $signed(din.quot)) : $signed(din.quot);

    // square halves of the scaled quotient, and the P8 term
    assign q13          = p0_p_reg >>> 13;
    assign ql           = q13[31:0];
    assign qh           = q13[63:32];
    assign p1_ll_next   = 64'(ql) * 64'(ql);
    assign p1_lh_next   = ql * qh;
    assign p1_eraw_next = p0_p_reg * 64'($signed(coef.p8));

    // assemble the square
    assign p2_qq_next = $signed(p1_ll_reg + {p1_lh_reg[30:0], 33'd0});
    assign p2_e_next  = p1_eraw_reg >>> 19;

    // P9 term
    assign p3_craw_next = p2_qq_reg * 64'($signed(coef.p9));

    // sum the corrections
    assign p4_s_next = p3_p_reg + (p3_craw_reg >>> 25) + p3_e_reg;

    // add the P7 offset and saturate
    assign pr = (p4_s_reg >>> 8) + (64'($signed(coef.p7)) <<< 4);
    always_comb
    begin
        if (!pv_reg[4] || pr[63])
        begin
            press = '0;
        end
        else if (pr[63:32] != '0)
        begin
            press = '1;
        end
        else
        begin
            press = pr[31:0];
        end
    end

    assign result_next.temperature_centi = side_reg[4].tcent;
    assign result_next.pressure_q24_8    = press;
    assign result_next.pressure_valid    = pv_reg[4];
    assign result_next.humidity_q22_10   = side_reg[4].hq;
    assign result_next.humidity_percent  = side_reg[4].hp;

    // advance the valid bits and the result strobe
    assign vld_next = {vld_reg[3:0], din.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[4];
        end
    end

    // pipeline registers
    always_ff @(posedge clk)
    begin
        pv_reg[0]   <= din.pvalid;
        side_reg[0] <= din.side;
        for (int i = 0; i < 4; i++)
        begin
            pv_reg[i+1]   <= pv_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
        p0_p_reg    <= p0_p_next;
        p1_ll_reg   <= p1_ll_next;
        p1_lh_reg   <= p1_lh_next;
        p1_eraw_reg <= p1_eraw_next;
        p1_p_reg    <= p0_p_reg;
        p2_qq_reg   <= p2_qq_next;
        p2_e_reg    <= p2_e_next;
        p2_p_reg    <= p1_p_reg;
        p3_craw_reg <= p3_craw_next;
        p3_e_reg    <= p2_e_reg;
        p3_p_reg    <= p2_p_reg;
        p4_s_reg    <= p4_s_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== sim/env_sensor_compensation_test.sv =====
// Testbench for env_sensor_compensation: drives raw sensor samples and calibration sets,
// predicts each compensated result in SV and checks it on done. Depends on ecomp_pkg.
module env_sensor_compensation_test
    import ecomp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 60;
    localparam int NUM_REGS     = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    sample_t               sample;
    logic                  done;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Calibration image as the block holds it, and the next set to load
    logic [47:0] cal [NUM_REGS];
    logic [47:0] cal_next [NUM_REGS];
    result_t     pending_results [$];
    int          error_count;
    bit          gaps_on;

    env_sensor_compensation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("env_sensor_compensation_test: done, errors");
        $finish;
    end

    function automatic logic [31:0] asr32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sx32(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx64(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Signed divide on magnitudes; most negative over -1 wraps
    function automatic logic [63:0] sdiv64(logic [63:0] n, logic [63:0] m);
        logic [63:0] mn;
        logic [63:0] mm;
        logic [63:0] q;
        mn = n[63] ? -n : n;
        mm = m[63] ? -m : m;
        q  = mn / mm;
        return (n[63] != m[63]) ? -q : q;
    endfunction

    function automatic result_t compensate(sample_t s);
        result_t     r;
        logic [31:0] at, t1, t2, t3, v1, d, v2, tf;
        logic [63:0] a, b, a2, a3, p, q, c, e;
        logic [31:0] h, x, y, hh, sq, hq;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        // temperature, 32-bit
        at = {12'd0, s.adc_temperature};
        t1 = {16'd0, cal[0][15:0]};
        t2 = sx32(cal[0][31:16]);
        t3 = sx32(cal[0][47:32]);
        v1 = asr32(((at >> 3) - (t1 << 1)) * t2, 11);
        d  = (at >> 4) - t1;
        v2 = asr32(asr32(d * d, 12) * t3, 14);
        tf = v1 + v2;
        r.temperature_centi = asr32(tf * 32'd5 + 32'd128, 8);
        // pressure, 64-bit
        a  = {{32{tf[31]}}, tf} - 64'd128000;
        b  = a * a * sx64(cal[2][47:32]);
        b  = b + ((a * sx64(cal[2][31:16])) << 17);
        b  = b + (sx64(cal[2][15:0]) << 35);
        a2 = asr64(a * a * sx64(cal[1][47:32]), 8) + ((a * sx64(cal[1][31:16])) << 12);
        a3 = asr64((64'h0000_8000_0000_0000 + a2) * {48'd0, cal[1][15:0]}, 33);
        r.pressure_q24_8 = '0;
        r.pressure_valid = 1'b0;
        if (a3 != 0)
        begin
            p = 64'd1048576 - {44'd0, s.adc_pressure};
            p = sdiv64(((p << 31) - b) * 64'd3125, a3);
            q = asr64(p, 13);
            c = asr64(sx64(cal[3][47:32]) * q * q, 25);
            e = asr64(sx64(cal[3][31:16]) * p, 19);
            p = asr64(p + c + e, 8) + (sx64(cal[3][15:0]) << 4);
            if (p[63])
                r.pressure_q24_8 = '0;
            else if (p[63:32] != 0)
                r.pressure_q24_8 = '1;
            else
                r.pressure_q24_8 = p[31:0];
            r.pressure_valid = 1'b1;
        end
        // humidity, 32-bit
        h1 = {24'd0, cal[4][7:0]};
        h2 = sx32(cal[4][23:8]);
        h3 = {24'd0, cal[4][31:24]};
        h4 = {{20{cal[5][11]}}, cal[5][11:0]};
        h5 = {{20{cal[5][23]}}, cal[5][23:12]};
        h6 = {{24{cal[5][31]}}, cal[5][31:24]};
        h  = tf - 32'd76800;
        x  = asr32(({16'd0, s.adc_humidity} << 14) - (h4 << 20) - h5 * h + 32'd16384, 15);
        y  = asr32(h * h6, 10) * (asr32(h * h3, 11) + 32'd32768);
        y  = asr32(y, 10) + 32'd2097152;
        y  = asr32(y * h2 + 32'd8192, 14);
        hh = x * y;
        sq = asr32(hh, 15);
        hh = hh - asr32(asr32(sq * sq, 7) * h1, 4);
        if (hh[31])
            hh = 0;
        else if (hh > 32'd419430400)
            hh = 32'd419430400;
        hq = hh >> 12;
        r.humidity_q22_10  = hq[16:0];
        r.humidity_percent = 7'((hq + 32'd512) >> 10);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Check every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", result.temperature_centi, 0);
            else
            begin
                want = pending_results.pop_front();
                if (result.temperature_centi !== want.temperature_centi)
                    report_mismatch("temperature_centi", result.temperature_centi,
                                    want.temperature_centi);
                if (result.pressure_q24_8 !== want.pressure_q24_8)
                    report_mismatch("pressure_q24_8", result.pressure_q24_8,
                                    want.pressure_q24_8);
                if (result.pressure_valid !== want.pressure_valid)
                    report_mismatch("pressure_valid", result.pressure_valid,
                                    want.pressure_valid);
                if (result.humidity_q22_10 !== want.humidity_q22_10)
                    report_mismatch("humidity_q22_10", result.humidity_q22_10,
                                    want.humidity_q22_10);
                if (result.humidity_percent !== want.humidity_percent)
                    report_mismatch("humidity_percent", result.humidity_percent,
                                    want.humidity_percent);
            end
        end
    end

    // Send one transaction; start stays high so the next one can follow back to back
    task automatic send_sample(sample_t s);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        start  <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(compensate(s));
    endtask

    // Hold off until every expected result is in, then let the pipe settle
    task automatic wait_idle();
        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all registers from cal_next, plus the unused indexes, which are dropped
    task automatic load_cal();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= (i < NUM_REGS) ? cal_next[i] : 48'({$urandom, $urandom});
            @(posedge clk);
            if (i < 4)
                cal[i] = cal_next[i];
            else if (i < NUM_REGS)
                cal[i] = {16'd0, cal_next[i][31:0]};
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pick_typical();
        cal_next[CFG_TEMP]    = {16'hFC18, 16'd26435, 16'd27504};
        cal_next[CFG_PRESS_A] = {16'd3024, 16'hD643, 16'd36477};
        cal_next[CFG_PRESS_B] = {16'hFFF9, 16'd140, 16'd2855};
        cal_next[CFG_PRESS_C] = {16'd6000, 16'hC6F8, 16'd15500};
        cal_next[CFG_HUM_A]   = {16'hA5A5, 8'd0, 16'd362, 8'd75};
        cal_next[CFG_HUM_B]   = {16'h5A5A, 8'd30, 12'd50, 12'd324};
    endtask

    task automatic pick_random();
        for (int i = 0; i < NUM_REGS; i++)
            cal_next[i] = 48'({$urandom, $urandom});
    endtask

    // Typical values with the low bits of every 16-bit slice nudged a little
    task automatic pick_nudged();
        pick_typical();
        for (int i = 0; i < NUM_REGS; i++)
            cal_next[i] = cal_next[i] ^ {3{4'd0, 12'($urandom_range(0, 63))}};
    endtask

    function automatic sample_t rand_sample(bit plausible);
        sample_t s;
        s = 56'({$urandom, $urandom});
        if (plausible)
        begin
            s.adc_pressure    = 20'($urandom_range(250000, 600000));
            s.adc_temperature = 20'($urandom_range(400000, 650000));
            s.adc_humidity    = 16'($urandom_range(15000, 50000));
        end
        return s;
    endfunction

    task automatic run_random(int n, int plausible_pct);
        for (int k = 0; k < n; k++)
            send_sample(rand_sample($urandom_range(0, 99) < plausible_pct));
    endtask

    task automatic test_reset_calibration();
        sample_t s;
        s = '0;
        send_sample(s);
        s = '1;
        send_sample(s);
        run_random(6, 0);
    endtask

    task automatic test_field_extremes();
        sample_t s;
        wait_idle();
        pick_typical();
        load_cal();
        s = '{20'd415148, 20'd519888, 16'd32000};
        send_sample(s);
        for (int k = 0; k < 8; k++)
        begin
            s.adc_pressure    = k[0] ? 20'hFFFFF : 20'd0;
            s.adc_temperature = k[1] ? 20'hFFFFF : 20'd0;
            s.adc_humidity    = k[2] ? 16'hFFFF : 16'd0;
            send_sample(s);
        end
        // humidity clamp at both ends
        s = '{20'd415148, 20'd519888, 16'hFFF0};
        send_sample(s);
        s = '{20'd415148, 20'd519888, 16'd100};
        send_sample(s);
    endtask

    task automatic test_zero_divisor();
        wait_idle();
        pick_typical();
        cal_next[CFG_PRESS_A][15:0] = 16'd0;
        load_cal();
        run_random(6, 50);
    endtask

    task automatic test_coefficient_extremes();
        wait_idle();
        for (int i = 0; i < NUM_REGS; i++)
            cal_next[i] = '1;
        load_cal();
        run_random(40, 30);
        wait_idle();
        cal_next[CFG_TEMP]    = {16'h8000, 16'h7FFF, 16'hFFFF};
        cal_next[CFG_PRESS_A] = {16'h7FFF, 16'h8000, 16'hFFFF};
        cal_next[CFG_PRESS_B] = {16'h8000, 16'h7FFF, 16'h8000};
        cal_next[CFG_PRESS_C] = {16'h7FFF, 16'h8000, 16'h7FFF};
        cal_next[CFG_HUM_A]   = {16'd0, 8'hFF, 16'h8000, 8'hFF};
        cal_next[CFG_HUM_B]   = {16'd0, 8'h80, 12'h7FF, 12'h800};
        load_cal();
        run_random(40, 30);
    endtask

    task automatic test_typical_random();
        wait_idle();
        pick_typical();
        load_cal();
        run_random(250, 70);
        // pause mid-stream until everything is back
        wait_idle();
        run_random(250, 70);
    endtask

    task automatic test_random_calibration();
        for (int set = 0; set < 8; set++)
        begin
            wait_idle();
            if (set[0])
                pick_random();
            else
                pick_nudged();
            load_cal();
            run_random(80, 60);
        end
    endtask

    task automatic test_back_to_back();
        wait_idle();
        pick_nudged();
        load_cal();
        gaps_on = 1'b0;
        run_random(500, 70);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        sample      = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        gaps_on     = 1'b1;
        for (int i = 0; i < NUM_REGS; i++)
            cal[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_calibration();
        test_field_extremes();
        test_zero_divisor();
        test_coefficient_extremes();
        test_typical_random();
        test_random_calibration();
        test_back_to_back();

        wait_idle();
        if (error_count == 0)
            $display("env_sensor_compensation_test: done, clean");
        else
            $display("env_sensor_compensation_test: done, errors");
        $finish;
    end
endmodule
